@@ src/tpl_pkg.sv @@
// Shared constants, codes and control types of the true-peak stereo limiter.
package tpl_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_FRAC = 23;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam int CEIL_W    = 23;
  localparam int COEF_W    = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int OS_FACTOR = 4;
  localparam int OS_SHIFT  = $clog2(OS_FACTOR);
  localparam int K_W       = OS_SHIFT;
  localparam int PEAK_W    = SAMPLE_W;
  localparam int MUL_W     = ((SAMPLE_W > COEF_W) ? SAMPLE_W : COEF_W) + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int QUO_W     = GAIN_FRAC;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  localparam logic [CEIL_W-1:0] CEIL_RST    = CEIL_W'(934537);
  localparam logic [COEF_W-1:0] ATTACK_RST  = COEF_W'(342345);
  localparam logic [COEF_W-1:0] RELEASE_RST = COEF_W'(2912);

  localparam logic [CFG_IDX_W-1:0] CFG_CEILING = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(2);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD_HELD,
    OP_LOAD_SELF,
    OP_PEAK,
    OP_MUL_TEST,
    OP_TEST,
    OP_DIV,
    OP_MUL_COEF,
    OP_GAIN,
    OP_MUL_L,
    OP_MUL_R,
    OP_EMIT,
    OP_HOLD,
    OP_GAIN_RESET
  } dp_op_t;

  typedef struct packed {
    dp_op_t         op;
    logic [K_W-1:0] k;
    logic           last;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
  } dp_stat_t;

endpackage

@@ src/tpl_dp.sv @@
// Datapath: config registers, held pair, peak search, shared multiplier, divider, gain, output.
module tpl_dp
  import tpl_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic signed [SAMPLE_W-1:0]  in_left,
  input  logic signed [SAMPLE_W-1:0]  in_right,
  input  dp_cmd_t                     cmd,
  output dp_stat_t                    stat,
  output logic signed [SAMPLE_W-1:0]  out_left,
  output logic signed [SAMPLE_W-1:0]  out_right,
  output logic                        out_last
);

  localparam int GS_W = PROD_W - GAIN_FRAC + 1;
  localparam logic signed [GS_W-1:0] GS_ONE = GS_W'(GAIN_ONE);

  logic [CEIL_W-1:0]          ceil_r;
  logic [COEF_W-1:0]          atk_r;
  logic [COEF_W-1:0]          rel_r;
  logic [GAIN_W-1:0]          gain_r;

  logic signed [SAMPLE_W-1:0] new_l_r, new_r_r;
  logic signed [SAMPLE_W-1:0] held_l_r, held_r_r;
  logic signed [SAMPLE_W-1:0] x0_l_r, x0_r_r, x1_l_r, x1_r_r;
  logic [PEAK_W-1:0]          peak_r;
  logic signed [PROD_W-1:0]   mul_r;
  logic [GAIN_W-1:0]          target_r;
  logic [PEAK_W-1:0]          rem_r;
  logic signed [SAMPLE_W-1:0] res_l_r;
  logic signed [SAMPLE_W-1:0] out_l_r, out_r_r;
  logic                       out_last_r;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic [PEAK_W-1:0]          mag_l, mag_r, mag_max;
  logic signed [GAIN_W:0]     diff;
  logic [COEF_W-1:0]          coef_sel;
  logic                       over;
  logic [PEAK_W:0]            rem2;
  logic                       rem_ge;
  logic signed [GS_W-2:0]     step;
  logic signed [GS_W-1:0]     gsum;

  function automatic logic [PEAK_W-1:0] point_mag(
    input logic signed [SAMPLE_W-1:0] x0,
    input logic signed [SAMPLE_W-1:0] x1,
    input logic [K_W-1:0]             k
  );
    logic signed [SAMPLE_W:0]         d;
    logic signed [SAMPLE_W+K_W+1:0]   dk;
    logic signed [SAMPLE_W:0]         p;
    logic [SAMPLE_W:0]                m;
    d  = (SAMPLE_W+1)'(x1) - (SAMPLE_W+1)'(x0);
    dk = (SAMPLE_W+K_W+2)'(d) * (SAMPLE_W+K_W+2)'($signed({1'b0, k}));
    p  = (SAMPLE_W+1)'(dk >>> OS_SHIFT) + (SAMPLE_W+1)'(x0);
    m  = p[SAMPLE_W] ? $unsigned(-p) : $unsigned(p);
    return m[PEAK_W-1:0];
  endfunction

  assign mag_l   = point_mag(x0_l_r, x1_l_r, cmd.k);
  assign mag_r   = point_mag(x0_r_r, x1_r_r, cmd.k);
  assign mag_max = (mag_l > mag_r) ? mag_l : mag_r;

  assign diff     = $signed({1'b0, target_r}) - $signed({1'b0, gain_r});
  assign coef_sel = (target_r < gain_r) ? atk_r : rel_r;
  assign over     = $unsigned(mul_r) > PROD_W'({ceil_r, GAIN_FRAC'(0)});
  assign stat.over = over;

  assign rem2   = {rem_r, 1'b0};
  assign rem_ge = rem2 >= {1'b0, peak_r};

  assign step = mul_r[PROD_W-1:GAIN_FRAC];
  assign gsum = GS_W'(step) + $signed(GS_W'({1'b0, gain_r}));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_TEST: begin
        mul_a = MUL_W'({1'b0, peak_r});
        mul_b = MUL_W'({1'b0, gain_r});
      end
      OP_MUL_COEF: begin
        mul_a = MUL_W'({1'b0, coef_sel});
        mul_b = MUL_W'(diff);
      end
      OP_MUL_L: begin
        mul_a = MUL_W'(x0_l_r);
        mul_b = MUL_W'({1'b0, gain_r});
      end
      OP_MUL_R: begin
        mul_a = MUL_W'(x0_r_r);
        mul_b = MUL_W'({1'b0, gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= CEIL_RST;
      atk_r  <= ATTACK_RST;
      rel_r  <= RELEASE_RST;
      gain_r <= GAIN_ONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CEILING: ceil_r <= cfg_data[CEIL_W-1:0];
          CFG_ATTACK:  atk_r  <= cfg_data[COEF_W-1:0];
          CFG_RELEASE: rel_r  <= cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_GAIN) begin
        if (gsum < 0) begin
          gain_r <= '0;
        end else if (gsum > GS_ONE) begin
          gain_r <= GAIN_ONE;
        end else begin
          gain_r <= gsum[GAIN_W-1:0];
        end
      end else if (cmd.op == OP_GAIN_RESET) begin
        gain_r <= GAIN_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_CAPTURE: begin
        new_l_r <= in_left;
        new_r_r <= in_right;
      end
      OP_LOAD_HELD: begin
        x0_l_r <= held_l_r;
        x0_r_r <= held_r_r;
        x1_l_r <= new_l_r;
        x1_r_r <= new_r_r;
        peak_r <= '0;
      end
      OP_LOAD_SELF: begin
        x0_l_r <= new_l_r;
        x0_r_r <= new_r_r;
        x1_l_r <= new_l_r;
        x1_r_r <= new_r_r;
        peak_r <= '0;
      end
      OP_PEAK: begin
        if (mag_max > peak_r) begin
          peak_r <= mag_max;
        end
      end
      OP_MUL_TEST, OP_MUL_COEF, OP_MUL_L: begin
        mul_r <= mul_a * mul_b;
      end
      OP_MUL_R: begin
        mul_r   <= mul_a * mul_b;
        res_l_r <= mul_r[GAIN_FRAC +: SAMPLE_W];
      end
      OP_TEST: begin
        target_r <= over ? '0 : GAIN_ONE;
        rem_r    <= PEAK_W'(ceil_r);
      end
      OP_DIV: begin
        rem_r    <= rem_ge ? rem2[PEAK_W-1:0] - peak_r : rem2[PEAK_W-1:0];
        target_r <= {target_r[GAIN_W-2:0], rem_ge};
      end
      OP_EMIT: begin
        out_l_r    <= res_l_r;
        out_r_r    <= mul_r[GAIN_FRAC +: SAMPLE_W];
        out_last_r <= cmd.last;
      end
      OP_HOLD: begin
        held_l_r <= new_l_r;
        held_r_r <= new_r_r;
      end
      default: ;
    endcase
  end

  assign out_left  = out_l_r;
  assign out_right = out_r_r;
  assign out_last  = out_last_r;

endmodule

@@ src/tpl_ctrl.sv @@
// Controller: sequences capture, peak search, limit test, division, gain update and output.
module tpl_ctrl
  import tpl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_PEAK,
    S_MUL_TEST,
    S_TEST,
    S_DIV,
    S_MUL_COEF,
    S_GAIN,
    S_MUL_L,
    S_MUL_R,
    S_EMIT,
    S_WRAP
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             holding_r, holding_nxt;
  logic             last_r, last_nxt;
  logic             self_r, self_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    holding_nxt   = holding_r;
    last_nxt      = last_r;
    self_nxt      = self_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.k         = cnt_r[K_W-1:0];
    cmd.last      = self_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op   = OP_CAPTURE;
          last_nxt = in_last;
          if (holding_r) begin
            self_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else if (in_last) begin
            self_nxt  = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_WRAP;
          end
        end
      end
      S_LOAD: begin
        cmd.op    = self_r ? OP_LOAD_SELF : OP_LOAD_HELD;
        cnt_nxt   = '0;
        state_nxt = S_PEAK;
      end
      S_PEAK: begin
        cmd.op = OP_PEAK;
        if (cnt_r == CNT_W'(OS_FACTOR - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL_TEST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL_TEST: begin
        cmd.op    = OP_MUL_TEST;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        cmd.op    = OP_TEST;
        cnt_nxt   = '0;
        state_nxt = stat.over ? S_DIV : S_MUL_COEF;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL_COEF;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL_COEF: begin
        cmd.op    = OP_MUL_COEF;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.op    = OP_MUL_L;
        state_nxt = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.op    = OP_MUL_R;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          if (!self_r && last_r) begin
            self_nxt  = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_WRAP;
          end
        end
      end
      S_WRAP: begin
        if (last_r) begin
          cmd.op      = OP_GAIN_RESET;
          holding_nxt = 1'b0;
        end else begin
          cmd.op      = OP_HOLD;
          holding_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      holding_r   <= 1'b0;
      last_r      <= 1'b0;
      self_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      holding_r   <= holding_nxt;
      last_r      <= last_nxt;
      self_r      <= self_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ src/true_peak_stereo_limiter.sv @@
// Top level of the true-peak stereo limiter: controller plus datapath.
//
//   port group  direction  beat contents
//   in_*        input      left/right sample pair, last flag
//   out_*       output     limited left/right pair, last flag
//   cfg_*       input      register write: ceiling, attack, release
//
// A pair that finds another pair held runs the peak search and limit test, then
// the 23-step restoring divider for the target gain when the peak is over the
// ceiling, then the gain update and output; a final pair adds a second pass on
// itself. A final pair with nothing held makes one pass; any other is only held.
// The multiplier is shared, so its operations run one per cycle in sequence.
// Synchronous reset restores the register defaults and unity gain, empty hold.
// A stalled output beat parks in the output register; the block waits only
// when the next result is ready and the previous one is still not taken.
module true_peak_stereo_limiter
  import tpl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  output logic                       out_last_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_sample),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_left   (in_left_sample),
    .in_right  (in_right_sample),
    .cmd       (cmd),
    .stat      (stat),
    .out_left  (out_left_out),
    .out_right (out_right_out),
    .out_last  (out_last_out)
  );

endmodule

@@ tb/sv/true_peak_stereo_limiter_tb.sv @@
// Self-checking testbench for the true-peak stereo limiter, with its own gain predictor.
module true_peak_stereo_limiter_tb;
  import tpl_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } stereo_beat_t;

  localparam int      RESET_CYCLES   = 6;
  localparam int      SETTLE_CYCLES  = 100;
  localparam int      WATCHDOG_LIMIT = 4000;
  localparam int      LONG_HOLD      = 500;
  localparam int      PHASE_ITEMS    = 322;
  localparam int      NUM_PHASES     = 6;
  localparam int      MAX_REPORTS    = 10;
  localparam longint  UNITY          = longint'(GAIN_ONE);
  localparam sample_t SMP_MAX        = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SMP_MIN        = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = CFG_CEILING;
  logic [CFG_W-1:0]     cfg_data        = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  sample_t              in_left_sample  = '0;
  sample_t              in_right_sample = '0;
  logic                 in_last_sample  = 1'b0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  sample_t              out_left_out;
  sample_t              out_right_out;
  logic                 out_last_out;

  true_peak_stereo_limiter i_dut (.*);

  always #2 clk = ~clk;

  stereo_beat_t pairs_to_send[$];
  stereo_beat_t limited_due[$];
  stereo_beat_t cur_beat;
  stereo_beat_t want;

  longint ceil_lvl  = longint'(CEIL_RST);
  longint attack_k  = longint'(ATTACK_RST);
  longint release_k = longint'(RELEASE_RST);
  longint held_l    = 0;
  longint held_r    = 0;
  bit     holding   = 1'b0;
  longint gain_lvl  = UNITY;

  bit quiet_gaps     = 1'b0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;
  int send_gap       = 0;
  int stall_cnt      = 0;
  int hold_cnt       = 0;
  int idle_cycles    = 0;

  int errors      = 0;
  int beats_in    = 0;
  int results_out = 0;
  int settings    = 0;
  int n_limit     = 0;
  int n_end_held  = 0;
  int n_end_lone  = 0;

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint interp_peak(longint x0, longint x1);
    longint d, best, p, m;
    int     k;
    d    = x1 - x0;
    best = 0;
    for (k = 0; k < OS_FACTOR; k++) begin
      p = x0 + floor_div(d * k, OS_FACTOR);
      m = (p < 0) ? -p : p;
      if (m > best) best = m;
    end
    return best;
  endfunction

  task automatic limit_held_pair(longint l0, longint r0, longint l1, longint r1,
                                 logic last_flag);
    longint       pk, pr, ceil_scaled, target, coef, g;
    stereo_beat_t res;
    pk = interp_peak(l0, l1);
    pr = interp_peak(r0, r1);
    if (pr > pk) pk = pr;
    ceil_scaled = ceil_lvl * UNITY;
    target      = UNITY;
    if (pk > 0 && pk * gain_lvl > ceil_scaled) begin
      target = ceil_scaled / pk;
      if (target > UNITY) target = UNITY;
      n_limit++;
    end
    coef = (target < gain_lvl) ? attack_k : release_k;
    g    = gain_lvl + floor_div(coef * (target - gain_lvl), UNITY);
    if (g < 0) g = 0;
    if (g > UNITY) g = UNITY;
    gain_lvl  = g;
    res.left  = sample_t'(floor_div(l0 * g, UNITY));
    res.right = sample_t'(floor_div(r0 * g, UNITY));
    res.last  = last_flag;
    limited_due.push_back(res);
  endtask

  task automatic predict_beat(stereo_beat_t b);
    longint l, r;
    l = longint'($signed(b.left));
    r = longint'($signed(b.right));
    if (holding) limit_held_pair(held_l, held_r, l, r, 1'b0);
    if (b.last) begin
      if (holding) n_end_held++;
      else n_end_lone++;
      limit_held_pair(l, r, l, r, 1'b1);
      gain_lvl = UNITY;
      holding  = 1'b0;
      held_l   = 0;
      held_r   = 0;
    end else begin
      held_l  = l;
      held_r  = r;
      holding = 1'b1;
    end
  endtask

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      3, 4:    return sample_t'(int'($urandom_range(0, 3 << 20)) - (3 << 19));
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic queue_pair(sample_t l, sample_t r, logic last_flag);
    stereo_beat_t b;
    b.left  = l;
    b.right = r;
    b.last  = last_flag;
    pairs_to_send.push_back(b);
  endtask

  task automatic queue_streams(int count);
    int len, i, queued;
    queued = 0;
    while (queued < count) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = $urandom_range(20, 60);
        default: len = $urandom_range(2, 12);
      endcase
      for (i = 0; i < len; i++) queue_pair(pick_sample(), pick_sample(), i == len - 1);
      queued += len;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    case (idx)
      CFG_CEILING: ceil_lvl = longint'(val & 32'h7F_FFFF);
      CFG_ATTACK:  attack_k = longint'(val & 32'hFF_FFFF);
      default:     release_k = longint'(val & 32'hFF_FFFF);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(int unsigned ceil_v, int unsigned atk_v, int unsigned rel_v);
    write_reg(CFG_CEILING, ceil_v);
    write_reg(CFG_ATTACK, atk_v);
    write_reg(CFG_RELEASE, rel_v);
    settings++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pairs_to_send.size() != 0 || in_valid || limited_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flag_error(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(cur_beat);
        beats_in++;
        send_gap = quiet_gaps ? 0 : idle_len();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pairs_to_send.size() != 0) begin
          cur_beat = pairs_to_send.pop_front();
          in_valid        <= 1'b1;
          in_left_sample  <= cur_beat.left;
          in_right_sample <= cur_beat.right;
          in_last_sample  <= cur_beat.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_out++;
      if (limited_due.size() == 0) begin
        flag_error($sformatf("unexpected beat L=%0d R=%0d last=%0b",
                             out_left_out, out_right_out, out_last_out));
      end else begin
        want = limited_due.pop_front();
        if (out_left_out !== want.left || out_right_out !== want.right ||
            out_last_out !== want.last)
          flag_error($sformatf("beat %0d: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                               results_out, want.left, want.right, want.last,
                               out_left_out, out_right_out, out_last_out));
      end
    end
    if (long_hold_req && !long_hold_done) begin
      hold_cnt       = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (stall_cnt != 0) begin
      stall_cnt--;
      out_stall <= 1'b1;
    end else begin
      stall_cnt = quiet_gaps ? 0 : idle_len();
      out_stall <= (stall_cnt != 0);
      if (stall_cnt != 0) stall_cnt--;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int p;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    queue_pair('0, '0, 1'b0);
    queue_pair(SMP_MAX, SMP_MIN, 1'b0);
    queue_pair(SMP_MIN, SMP_MAX, 1'b0);
    queue_pair(sample_t'(-1), sample_t'(1), 1'b0);
    queue_pair(sample_t'(1 << 20), sample_t'(-(1 << 20)), 1'b0);
    queue_pair('0, '0, 1'b0);
    queue_pair(SMP_MAX, SMP_MAX, 1'b1);
    queue_pair(SMP_MIN, SMP_MIN, 1'b1);
    queue_pair('0, '0, 1'b1);
    queue_pair(SMP_MAX, '0, 1'b0);
    queue_pair(SMP_MIN, '0, 1'b0);
    queue_pair('0, SMP_MAX, 1'b0);
    queue_pair('0, SMP_MIN, 1'b0);
    queue_pair(sample_t'(12345), sample_t'(-12345), 1'b1);
    queue_pair(sample_t'(1 << 19), sample_t'(-(1 << 19)), 1'b0);
    queue_pair(sample_t'(-1), sample_t'(-1), 1'b0);
    queue_pair(sample_t'(1), sample_t'(1), 1'b1);
    queue_pair(SMP_MIN, SMP_MAX, 1'b1);
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_limits(1 << 20, 1 << 23, 1 << 23);
        1: set_limits(0, 1 << 22, 256);
        2: set_limits((1 << 23) - 1, 0, 0);
        3: set_limits(600000, (1 << 24) - 1, (1 << 24) - 1);
        4: set_limits($urandom_range(0, (1 << 23) - 1), $urandom_range(0, 1 << 23),
                      $urandom_range(0, 1 << 23));
        default: set_limits(32'(CEIL_RST), 32'(ATTACK_RST), 32'(RELEASE_RST));
      endcase
      quiet_gaps = (p == 2);
      queue_streams(PHASE_ITEMS / 2);
      if (p == 2) long_hold_req = 1'b1;
      wait_idle();
      queue_streams(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_idle();
    end

    if (limited_due.size() != 0)
      flag_error($sformatf("%0d limited pairs never arrived", limited_due.size()));
    $display("Sent %0d pairs under %0d register settings, checked %0d limited pairs.",
             beats_in, settings, results_out);
    $display("Gain pulled down %0d times; %0d streams ended after a held pair, %0d alone.",
             n_limit, n_end_held, n_end_lone);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
